// File: rtl/julian_date_conversion_core_defines.svh
// assertion helpers shared by the conversion core
`ifndef JULIAN_DATE_CONVERSION_CORE_DEFINES_SVH
`define JULIAN_DATE_CONVERSION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define JDC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define JDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/jdc_pkg.sv
`default_nettype none

package jdc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned DN_W    = 23;
  localparam int unsigned DS_W    = 17;

  typedef enum logic {
    OP_TO_DAY = 1'b0,
    OP_TO_CAL = 1'b1
  } op_t;

  localparam logic [DN_W-1:0]   DAY_MIN     = 23'd1721424;
  localparam logic [DN_W-1:0]   DAY_MAX     = 23'd5373484;
  localparam logic [DN_W-1:0]   REFORM_DAY  = 23'd2299161;
  localparam logic [DS_W-1:0]   SEC_MAX     = 17'd86399;
  localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0] REFORM_YEAR = 14'd1582;

  // reciprocal constants: floor(n/d) = (n * M) >> SH; 2^SH > n_max * d holds for all but Q100
  localparam int unsigned     Q100_SH   = 19;
  localparam logic [12:0]     Q100_M    = 13'((64'd1 << Q100_SH) / 64'd100 + 64'd1);
  localparam int unsigned     QALPHA_SH = 42;
  localparam logic [24:0]     QALPHA_M  = 25'((64'd1 << QALPHA_SH) / 64'd146097 + 64'd1);
  localparam int unsigned     QC_SH     = 40;
  localparam logic [27:0]     QC_M      = 28'((64'd1 << QC_SH) / 64'd7305 + 64'd1);
  localparam int unsigned     QHR_SH    = 29;
  localparam logic [17:0]     QHR_M     = 18'((64'd1 << QHR_SH) / 64'd3600 + 64'd1);
  localparam int unsigned     QMIN_SH   = 18;
  localparam logic [12:0]     QMIN_M    = 13'((64'd1 << QMIN_SH) / 64'd60 + 64'd1);

  // floor(30.6 * k), shared by both directions
  function automatic logic [8:0] month_days(input logic [3:0] k);
    logic [8:0] r;
    unique case (k)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      4'd15: r = 9'd459;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jdc_if.sv
`default_nettype none

interface jdc_in_if;
  import jdc_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [YEAR_W-1:0]   cal_year;
  logic [MONTH_W-1:0]  cal_month;
  logic [DAY_W-1:0]    cal_day;
  logic [HOUR_W-1:0]   cal_hour;
  logic [MIN_W-1:0]    cal_minute;
  logic [SEC_W-1:0]    cal_second;
  logic [DN_W-1:0]     day_number_in;
  logic [DS_W-1:0]     day_seconds_in;

  modport source (
    output valid, operation, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_second, day_number_in, day_seconds_in,
    input  ready
  );

  modport sink (
    input  valid, operation, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_second, day_number_in, day_seconds_in,
    output ready
  );
endinterface

interface jdc_out_if;
  import jdc_pkg::*;

  logic                valid;
  logic                ready;
  logic [DN_W-1:0]     day_number_out;
  logic [DS_W-1:0]     day_seconds_out;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [HOUR_W-1:0]   out_hour;
  logic [MIN_W-1:0]    out_minute;
  logic [SEC_W-1:0]    out_second;
  logic                range_error;

  modport source (
    output valid, day_number_out, day_seconds_out, out_year, out_month, out_day,
           out_hour, out_minute, out_second, range_error,
    input  ready
  );

  modport sink (
    input  valid, day_number_out, day_seconds_out, out_year, out_month, out_day,
           out_hour, out_minute, out_second, range_error,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/julian_date_conversion_core.sv
// the result passes through the registers s1_r, s2_r, s3_r, s4_r and out_r in that order
// throughput: one transaction per cycle while out_ch.ready lets the output drain, each stage holds its own valid bit
// a stalled output only holds back the stages behind it that are full
// reset (rst_n low, synchronous) clears all valid bits; data registers are not reset
`default_nettype none
`include "julian_date_conversion_core_defines.svh"

module julian_date_conversion_core (
  input wire        clk,
  input wire        rst_n,
  jdc_in_if.sink    in_ch,
  jdc_out_if.source out_ch
);
  import jdc_pkg::*;

  localparam int unsigned PY_W   = YEAR_W + $bits(Q100_M);
  localparam int unsigned NA_W   = 24;
  localparam int unsigned PA_W   = NA_W + $bits(QALPHA_M);
  localparam int unsigned NC_W   = 27;
  localparam int unsigned PC_W   = NC_W + $bits(QC_M);
  localparam int unsigned PH_W   = DS_W + $bits(QHR_M);
  localparam int unsigned REM_W  = 12;
  localparam int unsigned PM_W   = REM_W + $bits(QMIN_M);
  localparam int unsigned C_W    = 14;
  localparam int unsigned BD_W   = 10;
  localparam int unsigned ALP_W  = PA_W - QALPHA_SH;
  localparam int unsigned YB_W   = PY_W - Q100_SH;

  localparam logic [DN_W+1:0] ALPHA_OFS = 25'd7468865;
  localparam logic [23:0]     E_STEP    = 24'd306001;

  typedef struct packed {
    op_t                op;
    logic               err;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   mday;
    logic               julian;
    logic [DS_W-1:0]    tod;
    logic [PY_W-1:0]    yq_prod;
    logic [DN_W-1:0]    z;
    logic               reform;
    logic [PA_W-1:0]    alpha_prod;
    logic [DS_W-1:0]    secs;
    logic [PH_W-1:0]    hr_prod;
  } s1_t;

  typedef struct packed {
    op_t                op;
    logic               err;
    logic [DN_W-1:0]    jd;
    logic [DS_W-1:0]    tod;
    logic [DN_W-1:0]    b;
    logic [NC_W-1:0]    nc;
    logic [HOUR_W-1:0]  hour;
    logic [REM_W-1:0]   rem;
  } s2_t;

  typedef struct packed {
    op_t                op;
    logic               err;
    logic [DN_W-1:0]    jd;
    logic [DS_W-1:0]    tod;
    logic [DN_W-1:0]    b;
    logic [PC_W-1:0]    c_prod;
    logic [HOUR_W-1:0]  hour;
    logic [REM_W-1:0]   rem;
    logic [PM_W-1:0]    min_prod;
  } s3_t;

  typedef struct packed {
    op_t                op;
    logic               err;
    logic [DN_W-1:0]    jd;
    logic [DS_W-1:0]    tod;
    logic [C_W-1:0]     c;
    logic [BD_W-1:0]    bd;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } s4_t;

  typedef struct packed {
    logic [DN_W-1:0]    day_number_out;
    logic [DS_W-1:0]    day_seconds_out;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [HOUR_W-1:0]  out_hour;
    logic [MIN_W-1:0]   out_minute;
    logic [SEC_W-1:0]   out_second;
    logic               range_error;
  } out_t;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  out_t out_r, out_nxt;

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic s1_go, s2_go, s3_go, s4_go, out_go;

  // a stage loads when it is empty or its content moves on
  assign out_go = !out_valid_r || out_ch.ready;
  assign s4_go  = !s4_valid_r || out_go;
  assign s3_go  = !s3_valid_r || s4_go;
  assign s2_go  = !s2_valid_r || s3_go;
  assign s1_go  = !s1_valid_r || s2_go;

  assign in_ch.ready = s1_go;

  // stage 1: range checks, date adjust, first reciprocal products
  logic                early_mon;
  logic [NA_W-1:0]     nal;

  always_comb begin
    early_mon = in_ch.cal_month <= 4'd2;
    nal       = NA_W'({in_ch.day_number_in, 2'b00} - ALPHA_OFS);

    s1_nxt.op = in_ch.operation;
    if (in_ch.operation == OP_TO_DAY) begin
      s1_nxt.err = (in_ch.cal_year == '0) || (in_ch.cal_year > YEAR_MAX) ||
                   (in_ch.cal_month == '0) || (in_ch.cal_month > 4'd12) ||
                   (in_ch.cal_day == '0) || (in_ch.cal_hour > 5'd23) ||
                   (in_ch.cal_minute > 6'd59) || (in_ch.cal_second > 6'd59);
    end else begin
      s1_nxt.err = (in_ch.day_number_in < DAY_MIN) || (in_ch.day_number_in > DAY_MAX) ||
                   (in_ch.day_seconds_in > SEC_MAX);
    end

    s1_nxt.y      = early_mon ? in_ch.cal_year - 14'd1 : in_ch.cal_year;
    s1_nxt.m      = early_mon ? in_ch.cal_month + 4'd12 : in_ch.cal_month;
    s1_nxt.mday   = in_ch.cal_day;
    s1_nxt.julian = (in_ch.cal_year < REFORM_YEAR) ||
                    ((in_ch.cal_year == REFORM_YEAR) &&
                     ((in_ch.cal_month < 4'd10) ||
                      ((in_ch.cal_month == 4'd10) && (in_ch.cal_day < 5'd15))));
    s1_nxt.tod    = DS_W'(in_ch.cal_second) +
                    DS_W'(DS_W'(in_ch.cal_minute) * DS_W'(60)) +
                    DS_W'(DS_W'(in_ch.cal_hour) * DS_W'(3600));
    s1_nxt.yq_prod = PY_W'(s1_nxt.y) * PY_W'(Q100_M);

    s1_nxt.z          = in_ch.day_number_in;
    s1_nxt.reform     = in_ch.day_number_in >= REFORM_DAY;
    s1_nxt.alpha_prod = PA_W'(nal) * PA_W'(QALPHA_M);
    s1_nxt.secs       = in_ch.day_seconds_in;
    s1_nxt.hr_prod    = PH_W'(in_ch.day_seconds_in) * PH_W'(QHR_M);
  end

  // stage 2: day number finished; century correction and hour for the other way
  logic [YB_W-1:0]  yb;
  logic [24:0]      t1461;
  logic [DN_W-1:0]  jd0;
  logic [ALP_W-1:0] alpha;
  logic [DN_W-1:0]  a;

  always_comb begin
    yb    = s1_r.yq_prod[PY_W-1:Q100_SH];
    t1461 = 25'(15'(s1_r.y) + 15'd4716) * 25'd1461;
    jd0   = DN_W'(t1461 >> 2) + DN_W'(month_days(s1_r.m + 4'd1)) + DN_W'(s1_r.mday);
    alpha = s1_r.alpha_prod[PA_W-1:QALPHA_SH];
    a     = s1_r.reform ? s1_r.z + DN_W'(1) + DN_W'(alpha) - DN_W'(alpha >> 2) : s1_r.z;

    s2_nxt.op  = s1_r.op;
    s2_nxt.err = s1_r.err;
    if (s1_r.julian) begin
      s2_nxt.jd = jd0 - DN_W'(1524);
    end else begin
      s2_nxt.jd = jd0 + DN_W'(2) + DN_W'(yb >> 2) - DN_W'(yb) - DN_W'(1524);
    end
    s2_nxt.tod  = s1_r.tod;
    s2_nxt.b    = a + DN_W'(1524);
    s2_nxt.nc   = NC_W'(NC_W'(s2_nxt.b) * NC_W'(20) - NC_W'(2442));
    s2_nxt.hour = HOUR_W'(s1_r.hr_prod[PH_W-1:QHR_SH]);
    s2_nxt.rem  = REM_W'(s1_r.secs - DS_W'(s2_nxt.hour) * DS_W'(3600));
  end

  // stage 3: year count and minute products
  always_comb begin
    s3_nxt.op       = s2_r.op;
    s3_nxt.err      = s2_r.err;
    s3_nxt.jd       = s2_r.jd;
    s3_nxt.tod      = s2_r.tod;
    s3_nxt.b        = s2_r.b;
    s3_nxt.c_prod   = PC_W'(s2_r.nc) * PC_W'(QC_M);
    s3_nxt.hour     = s2_r.hour;
    s3_nxt.rem      = s2_r.rem;
    s3_nxt.min_prod = PM_W'(s2_r.rem) * PM_W'(QMIN_M);
  end

  // stage 4: days into the shifted year, minute and second
  logic [DN_W-1:0] dyear;

  always_comb begin
    s4_nxt.op     = s3_r.op;
    s4_nxt.err    = s3_r.err;
    s4_nxt.jd     = s3_r.jd;
    s4_nxt.tod    = s3_r.tod;
    s4_nxt.c      = C_W'(s3_r.c_prod[PC_W-1:QC_SH]);
    dyear         = DN_W'((25'(s4_nxt.c) * 25'd1461) >> 2);
    s4_nxt.bd     = BD_W'(s3_r.b - dyear);
    s4_nxt.hour   = s3_r.hour;
    s4_nxt.minute = MIN_W'(s3_r.min_prod[PM_W-1:QMIN_SH]);
    s4_nxt.second = SEC_W'(s3_r.rem - REM_W'(s4_nxt.minute) * REM_W'(60));
  end

  // stage 5: month index by threshold compare, then day, month, year and zeroing
  logic [23:0]        bdx;
  logic [3:0]         e;
  logic [MONTH_W-1:0] mon;
  logic [BD_W-1:0]    day_full;

  always_comb begin
    bdx = 24'(s4_r.bd) * 24'd10000;
    e   = '0;
    // thresholds rise with k, so the last one passed wins
    for (int k = 1; k < 16; k++) begin
      if (bdx >= 24'(E_STEP * 24'(k))) begin
        e = 4'(k);
      end
    end
    mon      = (e < 4'd14) ? e - 4'd1 : e - 4'd13;
    day_full = s4_r.bd - BD_W'(month_days(e));

    out_nxt = '0;
    out_nxt.range_error = s4_r.err;
    if (!s4_r.err) begin
      if (s4_r.op == OP_TO_DAY) begin
        out_nxt.day_number_out  = s4_r.jd;
        out_nxt.day_seconds_out = s4_r.tod;
      end else begin
        out_nxt.out_year   = (mon > 4'd2) ? YEAR_W'(s4_r.c - C_W'(4716))
                                          : YEAR_W'(s4_r.c - C_W'(4715));
        out_nxt.out_month  = mon;
        out_nxt.out_day    = DAY_W'(day_full);
        out_nxt.out_hour   = s4_r.hour;
        out_nxt.out_minute = s4_r.minute;
        out_nxt.out_second = s4_r.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go)  s1_valid_r  <= in_ch.valid;
      if (s2_go)  s2_valid_r  <= s1_valid_r;
      if (s3_go)  s3_valid_r  <= s2_valid_r;
      if (s4_go)  s4_valid_r  <= s3_valid_r;
      if (out_go) out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go)  s1_r  <= s1_nxt;
    if (s2_go)  s2_r  <= s2_nxt;
    if (s3_go)  s3_r  <= s3_nxt;
    if (s4_go)  s4_r  <= s4_nxt;
    if (out_go) out_r <= out_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.day_number_out  = out_r.day_number_out;
  assign out_ch.day_seconds_out = out_r.day_seconds_out;
  assign out_ch.out_year        = out_r.out_year;
  assign out_ch.out_month       = out_r.out_month;
  assign out_ch.out_day         = out_r.out_day;
  assign out_ch.out_hour        = out_r.out_hour;
  assign out_ch.out_minute      = out_r.out_minute;
  assign out_ch.out_second      = out_r.out_second;
  assign out_ch.range_error     = out_r.range_error;

  `JDC_ASSERT_NOW(a_err_zeroes, out_valid_r && out_r.range_error,
                  out_r.day_number_out == '0 && out_r.day_seconds_out == '0 &&
                  out_r.out_year == '0 && out_r.out_month == '0 && out_r.out_day == '0,
                  "range error result carries data")
  `JDC_ASSERT_NOW(a_one_direction, out_valid_r && out_r.day_number_out != '0,
                  out_r.out_month == '0 && out_r.out_day == '0 && out_r.out_year == '0,
                  "both directions filled in one result")
  `JDC_ASSERT_NOW(a_cal_sane, out_valid_r && out_r.out_month != '0,
                  out_r.out_month <= 4'd12 && out_r.out_day != '0 &&
                  out_r.out_year <= YEAR_MAX,
                  "calendar result out of range")
  `JDC_ASSERT_NEXT(a_s4_hold, s4_valid_r && !out_go, s4_valid_r && $stable(s4_r),
                   "stage four changed while blocked")

endmodule

`default_nettype wire

// File: dv/julian_date_conversion_core_tb.sv
`timescale 1ns / 100ps

module julian_date_conversion_core_tb;
  import jdc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct {
    op_t               operation;
    logic [YEAR_W-1:0] cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]  cal_day;
    logic [HOUR_W-1:0] cal_hour;
    logic [MIN_W-1:0]  cal_minute;
    logic [SEC_W-1:0]  cal_second;
    logic [DN_W-1:0]   day_number_in;
    logic [DS_W-1:0]   day_seconds_in;
    bit                drain_first;
  } date_request_t;

  typedef struct {
    logic [DN_W-1:0]    day_number;
    logic [DS_W-1:0]    day_seconds;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               range_error;
  } date_result_t;

  logic clk = 1'b0;
  logic rst_n;

  jdc_in_if  conv_in ();
  jdc_out_if conv_out ();

  julian_date_conversion_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (conv_in.sink),
    .out_ch (conv_out.source)
  );

  date_request_t pending_requests[$];
  date_result_t  predicted_dates[$];

  int unsigned cycle_count   = 0;
  int unsigned item_total    = 0;
  int unsigned accepted_total = 0;
  int unsigned results_seen  = 0;
  int unsigned to_day_seen   = 0;
  int unsigned to_cal_seen   = 0;
  int unsigned range_err_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned src_gap       = 0;
  int unsigned sink_gap      = 0;
  bit          in_taken      = 1'b0;
  bit          tail_phase    = 1'b0;

  always #10 clk = ~clk;

  // conversion predictor, exact integer form of the day number formulas
  function automatic date_result_t convert_date(date_request_t rq);
    date_result_t r;
    longint unsigned yr, mo, jdn, cent, z, alpha, a, b, c, d, e, mon, secs;
    bit julian;
    r = '{default: '0};
    if (rq.operation == OP_TO_DAY) begin
      if (rq.cal_year < 1 || rq.cal_year > YEAR_MAX || rq.cal_month < 1 ||
          rq.cal_month > 12 || rq.cal_day < 1 || rq.cal_day > 31 ||
          rq.cal_hour > 23 || rq.cal_minute > 59 || rq.cal_second > 59) begin
        r.range_error = 1'b1;
      end else begin
        yr = rq.cal_year;
        mo = rq.cal_month;
        if (mo <= 2) begin
          yr = yr - 1;
          mo = mo + 12;
        end
        // reform gap days (oct 5..14) still count as julian
        julian = (rq.cal_year < REFORM_YEAR) ||
                 (rq.cal_year == REFORM_YEAR &&
                  (rq.cal_month < 10 || (rq.cal_month == 10 && rq.cal_day < 15)));
        jdn = (1461 * (yr + 4716)) / 4 + (153 * (mo + 1)) / 5 + rq.cal_day;
        if (julian) begin
          jdn = jdn - 1524;
        end else begin
          cent = yr / 100;
          jdn = jdn + 2 + cent / 4 - cent - 1524;
        end
        secs = longint'(rq.cal_second) + 60 * (longint'(rq.cal_minute) +
               60 * longint'(rq.cal_hour));
        r.day_number  = jdn[DN_W-1:0];
        r.day_seconds = secs[DS_W-1:0];
      end
    end else begin
      z = rq.day_number_in;
      if (z < DAY_MIN || z > DAY_MAX || rq.day_seconds_in > SEC_MAX) begin
        r.range_error = 1'b1;
      end else begin
        if (z < REFORM_DAY) begin
          a = z;
        end else begin
          alpha = (4 * z - 7468865) / 146097;
          a = z + 1 + alpha - alpha / 4;
        end
        b = a + 1524;
        c = (20 * b - 2442) / 7305;
        d = (1461 * c) / 4;
        e = (10000 * (b - d)) / 306001;
        mon = (e < 14) ? e - 1 : e - 13;
        yr = (mon > 2) ? c - 4716 : c - 4715;
        jdn = b - d - (306001 * e) / 10000;
        secs = rq.day_seconds_in;
        r.year   = yr[YEAR_W-1:0];
        r.month  = mon[MONTH_W-1:0];
        r.day    = jdn[DAY_W-1:0];
        r.hour   = 5'((secs / 3600) & 64'h1F);
        r.minute = 6'(((secs / 60) % 60) & 64'h3F);
        r.second = 6'((secs % 60) & 64'h3F);
      end
    end
    return r;
  endfunction

  // fields of the other direction get random bits, the block must ignore them
  function automatic date_request_t calendar_request(int unsigned y, int unsigned m,
                                                    int unsigned d, int unsigned h,
                                                    int unsigned mi, int unsigned s);
    date_request_t rq;
    rq.operation      = OP_TO_DAY;
    rq.cal_year       = YEAR_W'(y);
    rq.cal_month      = MONTH_W'(m);
    rq.cal_day        = DAY_W'(d);
    rq.cal_hour       = HOUR_W'(h);
    rq.cal_minute     = MIN_W'(mi);
    rq.cal_second     = SEC_W'(s);
    rq.day_number_in  = DN_W'($urandom);
    rq.day_seconds_in = DS_W'($urandom);
    rq.drain_first    = 1'b0;
    return rq;
  endfunction

  function automatic date_request_t day_request(int unsigned dn, int unsigned ds);
    date_request_t rq;
    rq = calendar_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    rq.operation      = OP_TO_CAL;
    rq.day_number_in  = DN_W'(dn);
    rq.day_seconds_in = DS_W'(ds);
    return rq;
  endfunction

  function automatic date_request_t random_calendar_request();
    int unsigned y, m, d, sel;
    sel = $urandom_range(0, 7);
    if (sel < 2) begin
      y = $urandom_range(1581, 1583);
      m = $urandom_range(9, 11);
    end else if (sel == 2) begin
      y = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(9995, 9999);
      m = $urandom_range(1, 12);
    end else begin
      y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
    end
    d = $urandom_range(0, 3) == 0 ? $urandom_range(27, 31) : $urandom_range(1, 31);
    return calendar_request(y, m, d, $urandom_range(0, 23), $urandom_range(0, 59),
                            $urandom_range(0, 59));
  endfunction

  function automatic date_request_t random_day_request();
    int unsigned dn, ds, sel;
    sel = $urandom_range(0, 7);
    if (sel < 2)
      dn = REFORM_DAY - 40 + $urandom_range(0, 80);
    else if (sel == 2)
      dn = $urandom_range(0, 1) ? DAY_MIN + $urandom_range(0, 400)
                                : DAY_MAX - $urandom_range(0, 400);
    else
      dn = $urandom_range(DAY_MIN, DAY_MAX);
    case ($urandom_range(0, 5))
      0:       ds = 0;
      1:       ds = SEC_MAX;
      default: ds = $urandom_range(0, SEC_MAX);
    endcase
    return day_request(dn, ds);
  endfunction

  // well-formed request with exactly one field pushed out of range
  function automatic date_request_t broken_request();
    date_request_t rq;
    if ($urandom_range(0, 1)) begin
      rq = random_calendar_request();
      case ($urandom_range(0, 5))
        0: rq.cal_year   = YEAR_W'($urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383));
        1: rq.cal_month  = MONTH_W'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
        2: rq.cal_day    = '0;
        3: rq.cal_hour   = HOUR_W'($urandom_range(24, 31));
        4: rq.cal_minute = MIN_W'($urandom_range(60, 63));
        default: rq.cal_second = SEC_W'($urandom_range(60, 63));
      endcase
    end else begin
      rq = random_day_request();
      case ($urandom_range(0, 2))
        0: rq.day_number_in  = DN_W'($urandom_range(0, DAY_MIN - 1));
        1: rq.day_number_in  = DN_W'($urandom_range(DAY_MAX + 1, 23'h7FFFFF));
        default: rq.day_seconds_in = DS_W'($urandom_range(SEC_MAX + 1, 17'h1FFFF));
      endcase
    end
    return rq;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, predicted %0d (result %0d)",
                                name, got, want, results_seen));
  endtask

  // source side: one transaction at a time from the pending queue
  always @(negedge clk) begin
    date_request_t nxt;
    if (rst_n && (!conv_in.valid || in_taken)) begin
      in_taken = 1'b0;
      if (src_gap == 0 && !tail_phase && $urandom_range(0, 5) == 0)
        src_gap = $urandom_range(1, 8);
      if (src_gap > 0) begin
        src_gap--;
        conv_in.valid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        conv_in.valid <= 1'b0;
      end else if (pending_requests[0].drain_first && predicted_dates.size() != 0) begin
        conv_in.valid <= 1'b0;
      end else begin
        nxt = pending_requests.pop_front();
        conv_in.operation      <= nxt.operation;
        conv_in.cal_year       <= nxt.cal_year;
        conv_in.cal_month      <= nxt.cal_month;
        conv_in.cal_day        <= nxt.cal_day;
        conv_in.cal_hour       <= nxt.cal_hour;
        conv_in.cal_minute     <= nxt.cal_minute;
        conv_in.cal_second     <= nxt.cal_second;
        conv_in.day_number_in  <= nxt.day_number_in;
        conv_in.day_seconds_in <= nxt.day_seconds_in;
        conv_in.valid          <= 1'b1;
      end
    end
  end

  // sink side: backpressure in bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (sink_gap == 0 && !tail_phase && $urandom_range(0, 5) == 0)
        sink_gap = $urandom_range(1, 8);
      if (sink_gap > 0) begin
        sink_gap--;
        conv_out.ready <= 1'b0;
      end else begin
        conv_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    date_request_t got_req;
    date_result_t  want;
    cycle_count++;
    if (rst_n) begin
      if (conv_in.valid && conv_in.ready) begin
        got_req.operation      = conv_in.operation;
        got_req.cal_year       = conv_in.cal_year;
        got_req.cal_month      = conv_in.cal_month;
        got_req.cal_day        = conv_in.cal_day;
        got_req.cal_hour       = conv_in.cal_hour;
        got_req.cal_minute     = conv_in.cal_minute;
        got_req.cal_second     = conv_in.cal_second;
        got_req.day_number_in  = conv_in.day_number_in;
        got_req.day_seconds_in = conv_in.day_seconds_in;
        got_req.drain_first    = 1'b0;
        want = convert_date(got_req);
        predicted_dates.push_back(want);
        in_taken = 1'b1;
        accepted_total++;
        if (want.range_error)
          range_err_seen++;
        else if (got_req.operation == OP_TO_DAY)
          to_day_seen++;
        else
          to_cal_seen++;
        tail_phase = (accepted_total + TAIL_ITEMS >= item_total);
      end
      if (conv_out.valid && conv_out.ready) begin
        if (predicted_dates.size() == 0) begin
          report_mismatch("result transaction with no prediction waiting");
        end else begin
          want = predicted_dates.pop_front();
          check_field("day_number_out",  conv_out.day_number_out,  want.day_number);
          check_field("day_seconds_out", conv_out.day_seconds_out, want.day_seconds);
          check_field("out_year",        conv_out.out_year,        want.year);
          check_field("out_month",       conv_out.out_month,       want.month);
          check_field("out_day",         conv_out.out_day,         want.day);
          check_field("out_hour",        conv_out.out_hour,        want.hour);
          check_field("out_minute",      conv_out.out_minute,      want.minute);
          check_field("out_second",      conv_out.out_second,      want.second);
          check_field("range_error",     conv_out.range_error,     want.range_error);
          results_seen++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d of %0d results seen",
             cycle_count, results_seen, item_total);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    date_request_t rq;
    int unsigned sel;

    rst_n                  = 1'b0;
    conv_in.valid          = 1'b0;
    conv_in.operation      = OP_TO_DAY;
    conv_in.cal_year       = '0;
    conv_in.cal_month      = '0;
    conv_in.cal_day        = '0;
    conv_in.cal_hour       = '0;
    conv_in.cal_minute     = '0;
    conv_in.cal_second     = '0;
    conv_in.day_number_in  = '0;
    conv_in.day_seconds_in = '0;
    conv_out.ready         = 1'b0;

    // directed: range edges, calendar reform, out-of-range fields
    pending_requests.push_back(calendar_request(1, 1, 1, 0, 0, 0));
    pending_requests.push_back(calendar_request(9999, 12, 31, 23, 59, 59));
    pending_requests.push_back(calendar_request(1582, 10, 4, 12, 0, 0));
    pending_requests.push_back(calendar_request(1582, 10, 5, 6, 30, 15));
    pending_requests.push_back(calendar_request(1582, 10, 14, 23, 59, 59));
    pending_requests.push_back(calendar_request(1582, 10, 15, 0, 0, 1));
    pending_requests.push_back(calendar_request(2000, 2, 30, 1, 2, 3));
    pending_requests.push_back(calendar_request(1900, 2, 29, 4, 5, 6));
    pending_requests.push_back(calendar_request(0, 6, 15, 0, 0, 0));
    pending_requests.push_back(calendar_request(16383, 6, 15, 0, 0, 0));
    pending_requests.push_back(calendar_request(2024, 0, 15, 0, 0, 0));
    pending_requests.push_back(calendar_request(2024, 15, 15, 0, 0, 0));
    pending_requests.push_back(calendar_request(2024, 6, 0, 0, 0, 0));
    pending_requests.push_back(calendar_request(2024, 6, 15, 31, 0, 0));
    pending_requests.push_back(calendar_request(2024, 6, 15, 0, 63, 0));
    pending_requests.push_back(calendar_request(2024, 6, 15, 0, 0, 63));
    pending_requests.push_back(day_request(DAY_MIN, 0));
    pending_requests.push_back(day_request(DAY_MAX, SEC_MAX));
    pending_requests.push_back(day_request(REFORM_DAY - 1, 43200));
    pending_requests.push_back(day_request(REFORM_DAY, 1));
    pending_requests.push_back(day_request(DAY_MIN - 1, 0));
    pending_requests.push_back(day_request(DAY_MAX + 1, 0));
    pending_requests.push_back(day_request(23'h7FFFFF, 0));
    pending_requests.push_back(day_request(DAY_MIN, SEC_MAX + 1));
    pending_requests.push_back(day_request(DAY_MAX, 17'h1FFFF));

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)
        rq = random_calendar_request();
      else if (sel < 80)
        rq = random_day_request();
      else if (sel < 90)
        rq = broken_request();
      else
        rq = calendar_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (sel >= 90) begin
        rq.operation      = op_t'($urandom_range(0, 1));
        rq.day_number_in  = DN_W'($urandom);
        rq.day_seconds_in = DS_W'($urandom);
      end
      // hold the source until the pipeline is empty here
      rq.drain_first = (i == 0) || (i == RANDOM_ITEMS / 2);
      pending_requests.push_back(rq);
    end
    item_total = pending_requests.size();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (results_seen < item_total);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (predicted_dates.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                predicted_dates.size()));

    $display("checked %0d transactions: %0d date to day number, %0d day number to date,",
             results_seen, to_day_seen, to_cal_seen);
    $display("%0d with range_error; %0d mismatches", range_err_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/jdc_pkg.sv
rtl/jdc_if.sv
rtl/julian_date_conversion_core.sv
dv/julian_date_conversion_core_tb.sv
